// File: src/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    typedef enum logic [2:0] {
        ACT_START     = 3'd0,
        ACT_STOP      = 3'd1,
        ACT_WRITE     = 3'd2,
        ACT_READ      = 3'd3,
        ACT_WAIT_ACK  = 3'd4,
        ACT_SEND_ACK  = 3'd5,
        ACT_SEND_NACK = 3'd6
    } t_action;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_byte;
        logic [7:0] bus_sda_bits;
        logic       bus_sda_ack;
    } t_cmd_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_data;
        logic       ack_missing;
        logic       last_phase;
    } t_res;

    typedef struct packed {
        t_action    kind;
        logic [7:0] wbyte;
        logic [7:0] rbits;
        logic       rack;
    } t_cmd;

    localparam logic [15:0] PHASE_CLOCKS_RESET = 16'd10;
    localparam logic [2:0]  BYTE_LAST_BIT      = 3'd7;

endpackage

`default_nettype wire

// File: src/i2cm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front
    import i2cm_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_cmd_in i_cmd,
    output logic    o_full,
    output logic    o_q_valid,
    output t_cmd    o_q_cmd,
    input  wire     i_q_take
);

    logic r_head_v, n_head_v;
    logic r_tail_v, n_tail_v;
    t_cmd r_head, n_head;
    t_cmd r_tail, n_tail;
    t_cmd w_new;
    logic w_legal;
    logic w_wr;
    logic w_take;

    // drop unused action codes here
    always_comb begin
        unique case (i_cmd.action) inside
            ACT_START, ACT_STOP, ACT_WRITE, ACT_READ,
            ACT_WAIT_ACK, ACT_SEND_ACK, ACT_SEND_NACK: w_legal = 1'b1;
            default:                                  w_legal = 1'b0;
        endcase
    end

    assign w_new.kind  = t_action'(i_cmd.action);
    assign w_new.wbyte = i_cmd.write_byte;
    assign w_new.rbits = i_cmd.bus_sda_bits;
    assign w_new.rack  = i_cmd.bus_sda_ack;

    assign o_full    = r_tail_v;
    assign w_wr      = i_push && !r_tail_v && w_legal;
    assign w_take    = i_q_take && r_head_v;
    assign o_q_valid = r_head_v;
    assign o_q_cmd   = r_head;

    always_comb begin
        n_head_v = r_head_v;
        n_tail_v = r_tail_v;
        n_head   = r_head;
        n_tail   = r_tail;
        if (w_take) begin
            if (r_tail_v) begin
                n_head   = r_tail;
                n_tail_v = w_wr;
                n_tail   = w_new;
            end else begin
                n_head_v = w_wr;
                n_head   = w_new;
            end
        end else if (w_wr) begin
            if (!r_head_v) begin
                n_head_v = 1'b1;
                n_head   = w_new;
            end else begin
                n_tail_v = 1'b1;
                n_tail   = w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_tail_v <= n_tail_v;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

`default_nettype wire

// File: src/i2cm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back
    import i2cm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_take,
    input  wire  [15:0] i_phase_clocks,
    output logic        o_empty,
    input  wire         i_pop,
    output t_res        o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [7:0]  r_shift;
    logic [1:0]  r_step;
    logic [2:0]  r_bit;
    logic [15:0] r_timer;
    logic        r_scl;
    logic        r_sda;
    logic        r_out_v;
    t_res        r_out;

    logic        w_scl;
    logic        w_sda;
    logic        w_last;
    logic        w_wrap;
    logic        w_emit;
    t_res        w_res;

    assign o_q_take = (r_state == ST_IDLE) && i_q_valid;
    assign w_emit   = (r_state == ST_RUN) && (r_timer == 16'd0) && (!r_out_v || i_pop);
    assign o_empty  = !r_out_v;
    assign o_res    = r_out;

    // line levels of the phase at hand
    always_comb begin
        w_scl  = r_scl;
        w_sda  = r_sda;
        w_last = 1'b0;
        w_wrap = 1'b0;
        unique case (r_cmd.kind)
            ACT_START: begin
                case (r_step)
                    2'd0: begin w_scl = 1'b1; w_sda = 1'b1; end
                    2'd1: w_sda = 1'b0;
                    default: begin w_scl = 1'b0; w_last = 1'b1; end
                endcase
            end
            ACT_STOP: begin
                case (r_step)
                    2'd0: begin w_scl = 1'b1; w_sda = 1'b0; end
                    default: begin w_sda = 1'b1; w_last = 1'b1; end
                endcase
            end
            ACT_WRITE: begin
                case (r_step)
                    2'd0: w_sda = r_shift[7];
                    2'd1: w_scl = 1'b1;
                    default: begin
                        w_scl  = 1'b0;
                        w_wrap = 1'b1;
                        if (r_bit == BYTE_LAST_BIT) begin
                            w_sda  = 1'b1;
                            w_last = 1'b1;
                        end
                    end
                endcase
            end
            ACT_READ: begin
                case (r_step)
                    2'd0: w_scl = 1'b1;
                    default: begin
                        w_scl  = 1'b0;
                        w_wrap = 1'b1;
                        w_last = (r_bit == BYTE_LAST_BIT);
                    end
                endcase
            end
            ACT_WAIT_ACK, ACT_SEND_NACK: begin
                case (r_step)
                    2'd0: w_sda = 1'b1;
                    2'd1: w_scl = 1'b1;
                    default: begin w_scl = 1'b0; w_last = 1'b1; end
                endcase
            end
            ACT_SEND_ACK: begin
                case (r_step)
                    2'd0: w_sda = 1'b0;
                    2'd1: w_scl = 1'b1;
                    2'd2: w_scl = 1'b0;
                    default: begin w_sda = 1'b1; w_last = 1'b1; end
                endcase
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    // sda stays put through a read, so the wired-and uses the held level
    always_comb begin
        w_res.scl_level   = w_scl;
        w_res.sda_level   = w_sda;
        w_res.last_phase  = w_last;
        w_res.read_data   = (w_last && r_cmd.kind == ACT_READ) ?
                            (r_cmd.rbits & {8{r_sda}}) : 8'd0;
        w_res.ack_missing = (w_last && r_cmd.kind == ACT_WAIT_ACK) ? r_cmd.rack : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_timer <= 16'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_out_v <= 1'b0;
            r_step  <= 2'd0;
            r_bit   <= 3'd0;
        end else begin
            if (r_timer != 16'd0) begin
                r_timer <= r_timer - 16'd1;
            end
            if (w_emit) begin
                r_out_v <= 1'b1;
                r_scl   <= w_scl;
                r_sda   <= w_sda;
                r_timer <= i_phase_clocks - 16'd1;
                if (w_last) begin
                    r_state <= ST_IDLE;
                end
                if (w_wrap) begin
                    r_step <= 2'd0;
                    r_bit  <= r_bit + 3'd1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= ST_RUN;
                        r_step  <= 2'd0;
                        r_bit   <= 3'd0;
                    end
                end
                ST_RUN: begin
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        if (o_q_take) begin
            r_cmd   <= i_q_cmd;
            r_shift <= i_q_cmd.wbyte;
        end else if (w_emit && r_cmd.kind == ACT_WRITE && w_wrap) begin
            r_shift <= {r_shift[6:0], 1'b0};
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

// File: src/i2c_master_bit_engine.sv
// I2C master bit engine: turns bus commands into timed SCL/SDA phases.
// Input channel: a command item on i_cmd is taken on a clock edge with i_push
// high and o_full low. Unused action codes are taken and dropped, with no result.
// Commands wait in a two-entry queue, so up to two can be pushed ahead.
// Result channel: one item per bus phase on o_res while o_empty is low, taken
// on an edge with i_pop high. last_phase marks the end of a command and carries
// read_data or ack_missing.
// Timing: a phase timer, loaded from phase_clocks at each phase, holds each level
// pair until it runs out, and only then is the next phase produced; a write byte
// is made of 24 phases. The first phase of a command goes out through ST_RUN
// into the result register once it has reached the sequencer, the previous
// phase's hold time has run out and the result register is free or popped.
// A stalled result (i_pop low) holds the sequencer; the command queue keeps
// taking items until it is full.
// i_cfg_we with i_cfg_data sets phase_clocks; write only while idle.
// Reset: both lines released, queues empty, phase_clocks back to 10.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  t_cmd_in     i_cmd,
    output logic        o_full,
    output logic        o_empty,
    input  wire         i_pop,
    output t_res        o_res,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_data
);

    logic [15:0] r_phase_clocks;
    logic        w_q_valid;
    logic        w_q_take;
    t_cmd        w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_clocks <= PHASE_CLOCKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_clocks <= i_cfg_data;
        end
    end

    i2cm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_cmd     (i_cmd),
        .o_full    (o_full),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_take  (w_q_take)
    );

    i2cm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_take       (w_q_take),
        .i_phase_clocks (r_phase_clocks),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_res          (o_res)
    );

endmodule

`default_nettype wire
